// ===== rtl/core/ltcd_pkg.sv =====
package ltcd_pkg;

    localparam int unsigned IntervalW = 16;
    localparam int unsigned HalfBitW  = 12;
    localparam int unsigned TolW      = 11;
    localparam int unsigned FrameBits = 80;
    localparam int unsigned CountW    = 7;

    localparam logic [HalfBitW-1:0]  HALF_BIT_RST  = 12'd250;
    localparam logic [TolW-1:0]      TOL_RST       = 11'd83;
    localparam logic [TolW-1:0]      TOL_MIN       = 11'd30;
    localparam logic [IntervalW-1:0] MAX_INTERVAL  = 16'd5000;
    localparam logic [15:0]          SYNC_WORD     = 16'h3FFD;
    localparam logic [CountW-1:0]    FRAME_BITS_C  = 7'd80;
    // ceil(2^17 / 3): exact divide by three for any 12-bit value
    localparam logic [15:0]          RECIP3        = 16'd43691;

    typedef struct packed {
        logic ign;
        logic is_short;
        logic is_long;
    } ltcd_cls_t;

    typedef struct packed {
        logic       tc_valid;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [5:0] frame_number;
        logic       locked;
    } ltcd_result_t;

endpackage

// ===== rtl/core/ltcd_classify.sv =====
module ltcd_classify (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ltcd_pkg::HalfBitW-1:0]        cfg_wr_data,
    input  logic [ltcd_pkg::IntervalW-1:0]       interval_us,
    output ltcd_pkg::ltcd_cls_t                  cls
);

    logic [ltcd_pkg::HalfBitW-1:0] half_reg;
    logic [ltcd_pkg::TolW-1:0]     tol_reg;
    logic [ltcd_pkg::TolW-1:0]     tol_next;
    logic [27:0]                   prod;
    logic [ltcd_pkg::HalfBitW-1:0] quot;
    logic [12:0]                   h2;
    logic [12:0]                   slo;
    logic [12:0]                   shi;
    logic [13:0]                   llo;
    logic [13:0]                   lhi;
    logic [ltcd_pkg::IntervalW:0]  iv;

    // tolerance is worked out once, when the period is written
    assign prod = 28'(cfg_wr_data) * 28'(ltcd_pkg::RECIP3);
    assign quot = {1'b0, prod[27:17]};

    always_comb begin
        if (quot < 12'(ltcd_pkg::TOL_MIN)) begin
            tol_next = ltcd_pkg::TOL_MIN;
        end else begin
            tol_next = quot[ltcd_pkg::TolW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= ltcd_pkg::HALF_BIT_RST;
            tol_reg  <= ltcd_pkg::TOL_RST;
        end else if (cfg_wr_en) begin
            half_reg <= cfg_wr_data;
            tol_reg  <= tol_next;
        end
    end

    always_comb begin
        h2  = {half_reg, 1'b0};
        slo = (13'(half_reg) > 13'(tol_reg)) ? 13'(half_reg) - 13'(tol_reg) : 13'd0;
        shi = 13'(half_reg) + 13'(tol_reg);
        llo = (h2 > 13'(tol_reg)) ? 14'(h2 - 13'(tol_reg)) : 14'd0;
        lhi = 14'(h2) + 14'(tol_reg);
        iv  = 17'(interval_us);
        cls.ign      = (interval_us >= ltcd_pkg::MAX_INTERVAL) || (half_reg == '0);
        cls.is_short = (iv >= 17'(slo)) && (iv <= 17'(shi));
        cls.is_long  = (iv >= 17'(llo)) && (iv <= 17'(lhi));
    end

endmodule

// ===== rtl/core/ltcd_frame.sv =====
module ltcd_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  ltcd_pkg::ltcd_cls_t   cls,
    output ltcd_pkg::ltcd_result_t result
);

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_START = 3'b010,
        PH_MID   = 3'b100
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [ltcd_pkg::FrameBits-1:0]  hist_reg, hist_next;
    logic [ltcd_pkg::CountW-1:0]     count_reg, count_next;
    logic                            locked_reg, locked_next;

    logic                            push;
    logic                            push_bit;
    logic                            lose;
    logic [ltcd_pkg::FrameBits-1:0]  hist_sh;
    logic [ltcd_pkg::CountW-1:0]     count_inc;
    logic                            sync_hit;
    logic [6:0]                      ff, ss, mm, hh;
    logic                            in_range;

    // frame bit p sits at age 79-p; fields are sent LSB first
    function automatic logic [3:0] field4(input logic [79:0] h, input int unsigned start);
        logic [3:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            v[i] = h[79 - start - i];
        end
        return v;
    endfunction

    always_comb begin
        push       = 1'b0;
        push_bit   = 1'b0;
        lose       = 1'b0;
        phase_next = phase_reg;
        if (!cls.ign) begin
            unique case (phase_reg)
                PH_START: begin
                    if (cls.is_short) begin
                        phase_next = PH_MID;
                    end else if (cls.is_long) begin
                        push = 1'b1;
                    end else begin
                        lose = 1'b1;
                    end
                end
                PH_MID: begin
                    if (cls.is_short) begin
                        phase_next = PH_START;
                        push       = 1'b1;
                        push_bit   = 1'b1;
                    end else begin
                        lose = 1'b1;
                    end
                end
                default: begin
                    phase_next = (cls.is_short || cls.is_long) ? PH_START : PH_WAIT;
                end
            endcase
        end
    end

    always_comb begin
        hist_sh   = {hist_reg[ltcd_pkg::FrameBits-2:0], push_bit};
        count_inc = (count_reg < ltcd_pkg::FRAME_BITS_C) ? count_reg + 7'd1 : count_reg;
        sync_hit  = (count_inc == ltcd_pkg::FRAME_BITS_C)
                    && (hist_sh[15:0] == ltcd_pkg::SYNC_WORD);

        ff = 7'(field4(hist_sh, 0))  + 7'({2'b00, field4(hist_sh, 8)}  & 7'h03) * 7'd10;
        ss = 7'(field4(hist_sh, 16)) + 7'({3'b000, field4(hist_sh, 24)} & 7'h07) * 7'd10;
        mm = 7'(field4(hist_sh, 32)) + 7'({3'b000, field4(hist_sh, 40)} & 7'h07) * 7'd10;
        hh = 7'(field4(hist_sh, 48)) + 7'({3'b000, field4(hist_sh, 56)} & 7'h03) * 7'd10;
        in_range = (ff < 7'd60) && (ss < 7'd60) && (mm < 7'd60) && (hh < 7'd24);

        hist_next   = hist_reg;
        count_next  = count_reg;
        locked_next = locked_reg;
        result      = '0;
        if (lose) begin
            count_next  = '0;
            locked_next = 1'b0;
        end else if (push) begin
            hist_next  = hist_sh;
            count_next = count_inc;
            if (sync_hit) begin
                locked_next = 1'b1;
                count_next  = '0;
                if (in_range) begin
                    result.tc_valid     = 1'b1;
                    result.hours        = hh[4:0];
                    result.minutes      = mm[5:0];
                    result.seconds      = ss[5:0];
                    result.frame_number = ff[5:0];
                end
            end
        end
        result.locked = locked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            hist_reg   <= '0;
            count_reg  <= '0;
            locked_reg <= 1'b0;
        end else if (en) begin
            phase_reg  <= lose ? PH_WAIT : phase_next;
            hist_reg   <= hist_next;
            count_reg  <= count_next;
            locked_reg <= locked_next;
        end
    end

endmodule

// ===== rtl/core/ltc_biphase_timecode_decoder.sv =====
// LTC biphase-mark timecode decoder. Each request on the slave side carries the
// time in microseconds between successive edges of the LTC signal; each one yields
// exactly one result carrying the lock state and, when it closed a frame
// with a valid sync word and in-range BCD values, the decoded hours,
// minutes, seconds and frame (flagged in m_axis_tuser). One request is
// taken every clock cycle while the output is not stalled: the interval is
// classed against the half-bit windows into an input register, and the cell
// machine, 80-bit history and BCD decode then run into the output register.
// Write cfg_wr_data (half-bit period in us) only while no request is in
// flight; the tolerance, period/3 but at least 30, is computed at write time.
module ltc_biphase_timecode_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] interval_us
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                        // [22:17] frame_number, [23] locked
    output logic [0:0]  m_axis_tuser    // [0] timecode_valid
);

    ltcd_pkg::ltcd_cls_t    cls_comb;
    ltcd_pkg::ltcd_cls_t    cls_reg;
    ltcd_pkg::ltcd_result_t result;
    ltcd_pkg::ltcd_result_t out_reg;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    logic                   advance;

    ltcd_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .interval_us (s_axis_tdata),
        .cls         (cls_comb)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    ltcd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_valid_reg && advance),
        .cls     (cls_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cls_reg <= cls_comb;
        end
        if (in_valid_reg && advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.tc_valid;
    assign m_axis_tdata  = {out_reg.locked, out_reg.frame_number, out_reg.seconds,
                            out_reg.minutes, out_reg.hours};

endmodule

// ===== rtl/core/ltcd_checker.sv =====
module ltcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a decoded frame always comes with lock set
    a_tc_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23])
        else $error("timecode reported without lock");

    a_tc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[4:0] < 5'd24) && (m_axis_tdata[10:5] < 6'd60)
            && (m_axis_tdata[16:11] < 6'd60) && (m_axis_tdata[22:17] < 6'd60))
        else $error("timecode out of range");

    a_no_tc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[22:0] == 23'd0))
        else $error("timecode fields nonzero without valid timecode");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind ltc_biphase_timecode_decoder ltcd_checker u_ltcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
